### hw/rtl/rcppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcppm_pkg;

   // field widths of the transaction payloads and registers
   localparam int unsigned CH_IDX_W  = 3;
   localparam int unsigned CH_VAL_W  = 12;
   localparam int unsigned PW_W      = 12;
   localparam int unsigned FL_W      = 16;
   localparam int unsigned CNT_W     = 16;
   localparam int unsigned SEG_OUT_W = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   // request kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 2'd2;

   // register reset values
   localparam logic [PW_W-1:0] PW_RESET = 12'd500;
   localparam logic [FL_W-1:0] FL_RESET = 16'd20000;

   typedef struct packed {
      logic                req_type;
      logic [CH_IDX_W-1:0] channel_index;
      logic [CH_VAL_W-1:0] channel_value;
   } item_type;

   typedef struct packed {
      logic                 ppm_level;
      logic                 frame_start;
      logic [SEG_OUT_W-1:0] segment_now;
   } result_type;

   typedef struct packed {
      logic            enable;
      logic [PW_W-1:0] pulse_width;
      logic [FL_W-1:0] frame_length;
   } cfg_type;

endpackage

`default_nettype wire

### hw/rtl/rc_ppm_frame_generator.sv
// rc_ppm_frame_generator: pulse-position frame encoder for one output pin.
// Request channel (req_*): each transaction is either one microsecond tick
// (req_type = 0) or a write of one stored channel value (req_type = 1).
// Every request transaction gives exactly one response transaction (rsp_*)
// with the pin level, a frame-start flag and the segment being played.
// Register channel (csr_*): enable, pulse_width, frame_length, always ready;
// writing enable sends the sequencer back to segment zero, pin low.
// A request is first held in the input register, is processed by the
// sequencer when the skid entry is free, and its response is registered in
// the output register or the skid entry before rsp_valid shows it.
// Throughput: one transaction per cycle while the skid entry is free; the tick
// path is a down-counter with one subtract-and-compare for the next duration,
// all in a single stage. When the receiver stalls, a two-entry response
// buffer (output register plus skid) keeps taking work; req_ready drops only
// when both are full and the input register holds a transaction.
// Reset (synchronous): channel values zero, enable off, pulse_width 500,
// frame_length 20000, all buffers empty.
`timescale 1ns / 1ps
`default_nettype none

module rc_ppm_frame_generator #(
   parameter int NUM_CHANNELS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_type,
   input  wire logic [rcppm_pkg::CH_IDX_W-1:0]       req_channel_index,
   input  wire logic [rcppm_pkg::CH_VAL_W-1:0]       req_channel_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_ppm_level,
   output logic                                      rsp_frame_start,
   output logic [rcppm_pkg::SEG_OUT_W-1:0]           rsp_segment_now,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [rcppm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rcppm_pkg::CSR_DAT_W-1:0]      csr_data
);
   import rcppm_pkg::*;

   cfg_type    cfg_ff;
   logic       csr_fire;
   logic       seq_clear;

   item_type   item_ff;
   logic       in_valid_ff;
   logic       advance;

   result_type result;
   result_type rsp_ff;
   result_type skid_ff;
   logic       rsp_valid_ff;
   logic       skid_valid_ff;
   logic       pop;

   // register writes
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign seq_clear = csr_fire && (csr_index == CSR_ENABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.pulse_width  <= PW_RESET;
         cfg_ff.frame_length <= FL_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_ENABLE:       cfg_ff.enable       <= csr_data[0];
            CSR_PULSE_WIDTH:  cfg_ff.pulse_width  <= csr_data[PW_W-1:0];
            CSR_FRAME_LENGTH: cfg_ff.frame_length <= csr_data[FL_W-1:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // input register
   assign advance   = in_valid_ff && !skid_valid_ff;
   assign req_ready = !in_valid_ff || !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.req_type      <= req_type;
         item_ff.channel_index <= req_channel_index;
         item_ff.channel_value <= req_channel_value;
      end
   end

   // frame sequencer
   rcppm_seq #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .item       (item_ff),
      .cfg        (cfg_ff),
      .seq_clear  (seq_clear),
      .result     (result)
   );

   // response register with skid entry
   assign pop = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= advance;
         end
      end else if (advance) begin
         if (rsp_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (advance) begin
            rsp_ff <= result;
         end
      end else if (advance) begin
         if (rsp_valid_ff) begin
            skid_ff <= result;
         end else begin
            rsp_ff  <= result;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ppm_level   = rsp_ff.ppm_level;
   assign rsp_frame_start = rsp_ff.frame_start;
   assign rsp_segment_now = rsp_ff.segment_now;

   // skid entry is only used behind a full output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty output register");

   // frame start is always a low separator in segment zero
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_start) |->
         (!rsp_ff.ppm_level && (rsp_ff.segment_now == '0)))
      else $error("frame start outside low segment zero");

   // a full pipeline must stall the request side
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && skid_valid_ff) |-> !req_ready)
      else $error("request accepted with no room");

   // an unread response that is not popped stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire

### hw/rtl/rcppm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rcppm_seq #(
   parameter int NUM_CHANNELS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_valid,
   input  wire rcppm_pkg::item_type   item,
   input  wire rcppm_pkg::cfg_type    cfg,
   input  wire logic                  seq_clear,
   output rcppm_pkg::result_type      result
);
   import rcppm_pkg::*;

   localparam int SEG_COUNT = 2 * NUM_CHANNELS + 2;
   localparam int SEG_W     = $clog2(SEG_COUNT);
   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [CH_VAL_W-1:0] store_ff [NUM_CHANNELS];
   logic [CH_VAL_W-1:0] store_in [NUM_CHANNELS];
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic [CNT_W-1:0]    ticks_ff, ticks_in;
   logic [CNT_W-1:0]    next_dur_ff, next_dur_in;
   logic [CNT_W-1:0]    sum_ff, sum_in;
   logic                level_ff, level_in;
   logic                running_ff, running_in;

   logic [SEG_W-1:0]    seg_next;
   logic [CNT_W-1:0]    sum_base;
   logic [CNT_W-1:0]    ch_val;
   logic [CNT_W-1:0]    pw_ext;
   logic [CNT_W-1:0]    chan_dur;
   logic [CNT_W-1:0]    sync_dur;
   logic [CNT_W-1:0]    pw_len;
   logic [CNT_W-1:0]    odd_len;
   logic [CNT_W-1:0]    seg_len;

   // segment that starts when the current one runs out
   always_comb begin
      if (!running_ff || (seg_ff >= SEG_W'(SEG_COUNT - 1))) begin
         seg_next = '0;
      end else begin
         seg_next = seg_ff + SEG_W'(1);
      end
   end

   // durations latched when an even segment starts
   assign sum_base = (seg_next == '0) ? '0 : sum_ff;
   assign ch_val   = CNT_W'(store_ff[CH_W'(seg_next >> 1)]);
   assign pw_ext   = CNT_W'(cfg.pulse_width);
   assign chan_dur = (ch_val > pw_ext) ? (ch_val - pw_ext) : CNT_W'(1);
   assign sync_dur = (cfg.frame_length > sum_base) ? (cfg.frame_length - sum_base)
                                                   : CNT_W'(1);
   assign pw_len   = (pw_ext == '0) ? CNT_W'(1) : pw_ext;
   assign odd_len  = (next_dur_ff == '0) ? CNT_W'(1) : next_dur_ff;
   assign seg_len  = seg_next[0] ? odd_len : pw_len;

   // next state and result of the transaction in hand
   always_comb begin
      store_in    = store_ff;
      seg_in      = seg_ff;
      ticks_in    = ticks_ff;
      next_dur_in = next_dur_ff;
      sum_in      = sum_ff;
      level_in    = level_ff;
      running_in  = running_ff;
      result      = '0;
      if (item.req_type == REQ_WRITE) begin
         if (32'(item.channel_index) < NUM_CHANNELS) begin
            store_in[CH_W'(item.channel_index)] = item.channel_value;
         end
         result.ppm_level   = level_ff;
         result.segment_now = SEG_OUT_W'(seg_ff);
      end else if (!cfg.enable) begin
         seg_in      = '0;
         ticks_in    = '0;
         next_dur_in = '0;
         sum_in      = '0;
         level_in    = 1'b0;
         running_in  = 1'b0;
      end else if (!running_ff || (ticks_ff == '0)) begin
         running_in = 1'b1;
         seg_in     = seg_next;
         level_in   = seg_next[0];
         ticks_in   = seg_len - CNT_W'(1);
         if (!seg_next[0]) begin
            sum_in = sum_base;
            if (seg_next == SEG_W'(SEG_COUNT - 2)) begin
               next_dur_in = sync_dur;
            end else begin
               next_dur_in = chan_dur;
               sum_in      = sum_base + ch_val;
            end
         end
         result.ppm_level   = seg_next[0];
         result.frame_start = (seg_next == '0);
         result.segment_now = SEG_OUT_W'(seg_next);
      end else begin
         ticks_in           = ticks_ff - CNT_W'(1);
         result.ppm_level   = level_ff;
         result.segment_now = SEG_OUT_W'(seg_ff);
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            store_ff[i] <= '0;
         end
         seg_ff      <= '0;
         ticks_ff    <= '0;
         next_dur_ff <= '0;
         sum_ff      <= '0;
         level_ff    <= 1'b0;
         running_ff  <= 1'b0;
      end else if (seq_clear) begin
         seg_ff      <= '0;
         ticks_ff    <= '0;
         next_dur_ff <= '0;
         sum_ff      <= '0;
         level_ff    <= 1'b0;
         running_ff  <= 1'b0;
      end else if (step_valid) begin
         store_ff    <= store_in;
         seg_ff      <= seg_in;
         ticks_ff    <= ticks_in;
         next_dur_ff <= next_dur_in;
         sum_ff      <= sum_in;
         level_ff    <= level_in;
         running_ff  <= running_in;
      end
   end

   // pin stays low while the sequencer is idle
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> !level_ff)
      else $error("pin high while sequencer idle");

   // segment index never leaves the frame
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      32'(seg_ff) < SEG_COUNT)
      else $error("segment index out of range");

   // while running, odd segments are high and even segments low
   a_level_parity: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (level_ff == seg_ff[0]))
      else $error("pin level does not match segment parity");

endmodule

`default_nettype wire
